// ----- hdl/usb_console_event_tracker_macros.svh -----
// Assertion macros for the USB console event tracker checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef USB_CONSOLE_EVENT_TRACKER_MACROS_SVH
`define USB_CONSOLE_EVENT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define UCET_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define UCET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ucet_pkg.sv -----
// Shared types and constants of the USB console event tracker.
// Used by ucet_csr, ucet_core, usb_console_event_tracker and the testbench; no dependencies.
package ucet_pkg;

   // Fixed sizing of the tracked state
   localparam int RING_WORDS_MAX  = 16383;
   localparam int SIZE_FIELD_BITS = 24;
   localparam logic [23:0] SIZE_MASK = 24'((25'd1 << SIZE_FIELD_BITS) - 25'd1);
   localparam logic [13:0] RING_WORDS_CAP = 14'(RING_WORDS_MAX);

   // Register reset values
   localparam logic [4:0]  TX_EP_RESET        = 5'd1;
   localparam logic [4:0]  RX_EP_RESET        = 5'd2;
   localparam logic [10:0] PACKET_LIMIT_RESET = 11'd512;
   localparam logic [15:0] RING_BYTES_RESET   = 16'd4096;
   localparam logic [13:0] START_CURSOR_RESET = 14'd0;
   localparam logic [17:0] TX_TIMEOUT_RESET   = 18'd250000;

   // Register word indexes (byte address / 4)
   typedef enum logic [2:0] {
      CSR_TX_EP        = 3'd0,
      CSR_RX_EP        = 3'd1,
      CSR_PACKET_LIMIT = 3'd2,
      CSR_RING_BYTES   = 3'd3,
      CSR_START_CURSOR = 3'd4,
      CSR_TX_TIMEOUT   = 3'd5
   } csr_index_type;

   // Item kinds
   typedef enum logic [2:0] {
      KIND_EVENT    = 3'd0,
      KIND_COUNT    = 3'd1,
      KIND_TX_START = 3'd2,
      KIND_RX_USED  = 3'd3,
      KIND_RX_START = 3'd4,
      KIND_TICK     = 3'd5
   } kind_type;

   typedef struct packed {
      logic [4:0]  tx_endpoint_num;
      logic [4:0]  rx_endpoint_num;
      logic [10:0] packet_limit;
      logic [15:0] ring_bytes;
      logic [13:0] start_cursor;
      logic [17:0] tx_timeout_ticks;
   } cfg_type;

   // Cursor reload issued by a start_cursor write
   typedef struct packed {
      logic        load;
      logic [13:0] value;
   } cursor_ctl_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ev_word;
      logic [23:0] trb_remaining;
      logic [15:0] pending_bytes;
      logic        cmd_error;
      logic [10:0] consumed_bytes;
   } item_type;

   typedef struct packed {
      logic        tx_busy_flag;
      logic        rx_busy_flag;
      logic [10:0] rx_bytes_left;
      logic        link_failed;
      logic [13:0] ring_cursor;
      logic        event_acked;
      logic        rx_start_wanted;
      logic        tx_room;
   } result_type;

endpackage

// ----- hdl/ucet_csr.sv -----
// Configuration register file of the USB console event tracker (APB-style).
// Depends on ucet_pkg for the register indexes, reset values and cfg_type.
module ucet_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [4:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output ucet_pkg::cfg_type        cfg,
   output ucet_pkg::cursor_ctl_type cursor_ctl
);

   ucet_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wr_idx     = csr_paddr[4:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_idx)
            ucet_pkg::CSR_TX_EP:        cfg_in.tx_endpoint_num  = csr_pwdata[4:0];
            ucet_pkg::CSR_RX_EP:        cfg_in.rx_endpoint_num  = csr_pwdata[4:0];
            ucet_pkg::CSR_PACKET_LIMIT: cfg_in.packet_limit     = csr_pwdata[10:0];
            ucet_pkg::CSR_RING_BYTES:   cfg_in.ring_bytes       = csr_pwdata[15:0];
            ucet_pkg::CSR_START_CURSOR: cfg_in.start_cursor     = csr_pwdata[13:0];
            ucet_pkg::CSR_TX_TIMEOUT:   cfg_in.tx_timeout_ticks = csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_endpoint_num  <= ucet_pkg::TX_EP_RESET;
         cfg_ff.rx_endpoint_num  <= ucet_pkg::RX_EP_RESET;
         cfg_ff.packet_limit     <= ucet_pkg::PACKET_LIMIT_RESET;
         cfg_ff.ring_bytes       <= ucet_pkg::RING_BYTES_RESET;
         cfg_ff.start_cursor     <= ucet_pkg::START_CURSOR_RESET;
         cfg_ff.tx_timeout_ticks <= ucet_pkg::TX_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // A start_cursor write also reloads the ring cursor
   assign cursor_ctl.load  = wr_en && (wr_idx == ucet_pkg::CSR_START_CURSOR);
   assign cursor_ctl.value = csr_pwdata[13:0];

   // Read mux
   always_comb begin
      case (wr_idx)
         ucet_pkg::CSR_TX_EP:        csr_prdata = {27'd0, cfg_ff.tx_endpoint_num};
         ucet_pkg::CSR_RX_EP:        csr_prdata = {27'd0, cfg_ff.rx_endpoint_num};
         ucet_pkg::CSR_PACKET_LIMIT: csr_prdata = {21'd0, cfg_ff.packet_limit};
         ucet_pkg::CSR_RING_BYTES:   csr_prdata = {16'd0, cfg_ff.ring_bytes};
         ucet_pkg::CSR_START_CURSOR: csr_prdata = {18'd0, cfg_ff.start_cursor};
         ucet_pkg::CSR_TX_TIMEOUT:   csr_prdata = {14'd0, cfg_ff.tx_timeout_ticks};
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- hdl/ucet_core.sv -----
// Link state of the USB console event tracker: state registers and the
// single-pass update for one item. Depends on ucet_pkg.
module ucet_core (
   input  logic                     clock,
   input  logic                     reset,
   input  ucet_pkg::cfg_type         cfg,
   input  ucet_pkg::cursor_ctl_type  cursor_ctl,
   input  logic                     step,
   input  ucet_pkg::item_type        item,
   output ucet_pkg::result_type      result
);

   logic        tx_pending_ff, tx_pending_in;
   logic        rx_pending_ff, rx_pending_in;
   logic        fail_ff, fail_in;
   logic [10:0] rx_count_ff, rx_count_in;
   logic [17:0] tx_wait_ff, tx_wait_in;
   logic [13:0] cursor_ff, cursor_in;
   logic        acked;

   // Event word decode
   logic [4:0]  ep;
   logic        ep_tx, ep_rx;
   logic        dev_event;
   logic        dev_fail;
   logic        xfer_complete;
   logic [23:0] remaining;
   logic        remaining_big;
   logic [13:0] ring_words, words_cap;
   logic [14:0] cursor_inc;
   logic [13:0] cursor_next;
   logic [15:0] pend_masked;
   logic [17:0] wait_inc;

   assign ep            = item.ev_word[5:1];
   assign ep_tx         = (ep == cfg.tx_endpoint_num);
   assign ep_rx         = (ep == cfg.rx_endpoint_num);
   assign dev_event     = item.ev_word[0];
   // Device event: disconnect or bus reset
   assign dev_fail      = (item.ev_word[7:1] == 7'd0) &&
                          (item.ev_word[11:8] == 4'd0 || item.ev_word[11:8] == 4'd1);
   assign xfer_complete = (item.ev_word[9:6] == 4'd1);
   assign remaining     = item.trb_remaining & ucet_pkg::SIZE_MASK;
   assign remaining_big = (remaining > {13'd0, cfg.packet_limit});

   // Ring cursor advance with wrap
   assign ring_words  = cfg.ring_bytes[15:2];
   assign words_cap   = (ring_words > ucet_pkg::RING_WORDS_CAP) ? ucet_pkg::RING_WORDS_CAP
                                                                : ring_words;
   assign cursor_inc  = {1'b0, cursor_ff} + 15'd1;
   assign cursor_next = (cursor_inc >= {1'b0, words_cap}) ? 14'd0 : cursor_inc[13:0];

   assign pend_masked = {item.pending_bytes[15:2], 2'b00};
   assign wait_inc    = tx_wait_ff + 18'd1;

   // Next state for one item, or for a cursor reload, which takes priority
   always_comb begin
      tx_pending_in = tx_pending_ff;
      rx_pending_in = rx_pending_ff;
      fail_in       = fail_ff;
      rx_count_in   = rx_count_ff;
      tx_wait_in    = tx_wait_ff;
      cursor_in     = cursor_ff;
      acked         = 1'b0;
      if (cursor_ctl.load) begin
         cursor_in = cursor_ctl.value;
      end else if (step && !fail_ff) begin
         case (item.kind)
            ucet_pkg::KIND_EVENT: begin
               if (!dev_event && !ep_tx && !ep_rx) begin
                  fail_in = 1'b1;
               end else begin
                  cursor_in = cursor_next;
                  acked     = 1'b1;
                  if (dev_event) begin
                     if (dev_fail) fail_in = 1'b1;
                  end else if (xfer_complete) begin
                     if (item.ev_word[12]) begin
                        fail_in = 1'b1;
                     end else if (ep_tx) begin
                        tx_pending_in = 1'b0;
                     end else if (remaining_big) begin
                        fail_in = 1'b1;
                     end else begin
                        rx_pending_in = 1'b0;
                        rx_count_in   = cfg.packet_limit - remaining[10:0];
                     end
                  end
               end
            end
            ucet_pkg::KIND_COUNT: begin
               if (pend_masked > cfg.ring_bytes) fail_in = 1'b1;
            end
            ucet_pkg::KIND_TX_START: begin
               if (!tx_pending_ff) begin
                  if (item.cmd_error) begin
                     fail_in = 1'b1;
                  end else begin
                     tx_pending_in = 1'b1;
                     tx_wait_in    = 18'd0;
                  end
               end
            end
            ucet_pkg::KIND_RX_USED: begin
               rx_count_in = (item.consumed_bytes >= rx_count_ff) ? 11'd0
                                                                   : rx_count_ff - item.consumed_bytes;
            end
            ucet_pkg::KIND_RX_START: begin
               if (!rx_pending_ff && rx_count_ff == 11'd0) begin
                  if (item.cmd_error) fail_in = 1'b1;
                  else                rx_pending_in = 1'b1;
               end
            end
            ucet_pkg::KIND_TICK: begin
               if (tx_pending_ff) begin
                  tx_wait_in = wait_inc;
                  if (wait_inc >= cfg.tx_timeout_ticks) fail_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_pending_ff <= 1'b0;
         rx_pending_ff <= 1'b0;
         fail_ff       <= 1'b0;
         rx_count_ff   <= 11'd0;
         tx_wait_ff    <= 18'd0;
         cursor_ff     <= ucet_pkg::START_CURSOR_RESET;
      end else begin
         tx_pending_ff <= tx_pending_in;
         rx_pending_ff <= rx_pending_in;
         fail_ff       <= fail_in;
         rx_count_ff   <= rx_count_in;
         tx_wait_ff    <= tx_wait_in;
         cursor_ff     <= cursor_in;
      end
   end

   // Result reflects the state after this item
   assign result.tx_busy_flag    = tx_pending_in;
   assign result.rx_busy_flag    = rx_pending_in;
   assign result.rx_bytes_left   = rx_count_in;
   assign result.link_failed     = fail_in;
   assign result.ring_cursor     = cursor_in;
   assign result.event_acked     = acked;
   assign result.rx_start_wanted = !fail_in && !rx_pending_in && (rx_count_in == 11'd0);
   assign result.tx_room         = !fail_in && !tx_pending_in;

endmodule

// ----- hdl/usb_console_event_tracker.sv -----
// USB console event tracker (top level): stream channels, input and result
// registers around ucet_core, APB-style registers in ucet_csr. Depends on ucet_pkg.
//
// Usage:
//   req_ channel carries one item per transaction: an event word with the
//   receive descriptor's remaining size, a pending-count reading, a transmit
//   or receive start, consumed receive bytes, or a timeout tick (kind in tuser).
//   rsp_ channel returns exactly one result per item, in order: busy flags,
//   receive bytes left, sticky failure, ring cursor, event acknowledge and
//   the two "may start" hints.
//   Each item is held in the input register, updated through ucet_core into
//   the result register once that register is free, and offered on rsp_.
//   Throughput: one item per cycle while rsp_ takes each result, set by the
//   single-pass state update. A stalled rsp_ side holds its result; one more
//   item waits in the input register, after which req_tready drops until the
//   result is taken. Reset clears all flags, counters and the cursor, and
//   loads the register reset values; no clearing pass is needed. The user
//   must write registers only while the block is idle; the block does not
//   enforce it. A start_cursor write also reloads the ring cursor.
module usb_console_event_tracker (
   input  logic        clock,
   input  logic        reset,
   // Item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] raw event word, [55:32] trb_remaining, [71:56] pending_bytes,
   // [72] cmd_error, [83:73] consumed_bytes, [87:84] zero
   input  logic [87:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]  req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_busy_flag, [1] rx_busy_flag, [12:2] rx_bytes_left, [13] link_failed,
   // [27:14] ring_cursor, [28] event_acked, [29] rx_start_wanted, [30] tx_room,
   // [31] zero
   output logic [31:0] rsp_tdata,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ucet_pkg::cfg_type        cfg;
   ucet_pkg::cursor_ctl_type cursor_ctl;
   ucet_pkg::item_type       item_ff, item_in;
   ucet_pkg::result_type     result, rsp_ff;
   logic                     in_valid_ff, in_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     advance;
   logic                     req_take;

   ucet_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cursor_ctl  (cursor_ctl)
   );

   // Handshake: the update stage moves when the result register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Unpack the incoming transaction
   assign item_in.kind           = req_tuser;
   assign item_in.ev_word        = req_tdata[31:0];
   assign item_in.trb_remaining  = req_tdata[55:32];
   assign item_in.pending_bytes  = req_tdata[71:56];
   assign item_in.cmd_error      = req_tdata[72];
   assign item_in.consumed_bytes = req_tdata[83:73];

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   ucet_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cursor_ctl (cursor_ctl),
      .step       (advance),
      .item       (item_ff),
      .result     (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.tx_room, rsp_ff.rx_start_wanted, rsp_ff.event_acked,
                        rsp_ff.ring_cursor, rsp_ff.link_failed, rsp_ff.rx_bytes_left,
                        rsp_ff.rx_busy_flag, rsp_ff.tx_busy_flag};

endmodule

// ----- hdl/ucet_checker.sv -----
// Port-level checker for usb_console_event_tracker, bound to the top level.
// Depends on usb_console_event_tracker_macros.svh.
`include "usb_console_event_tracker_macros.svh"

module ucet_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic seen_failed_ff, seen_failed_in;

   // Remember that a delivered result reported a failed link
   assign seen_failed_in = seen_failed_ff || (rsp_tvalid && rsp_tready && rsp_tdata[13]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_failed_ff <= 1'b0;
      end else begin
         seen_failed_ff <= seen_failed_in;
      end
   end

   // A stalled result holds
   `UCET_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Failure never clears once reported
   `UCET_ASSERT_NOW(a_fail_sticky, rsp_tvalid && seen_failed_ff, rsp_tdata[13], "link failure cleared")

   // Transmit room agrees with busy and failure
   `UCET_ASSERT_NOW(a_tx_room, rsp_tvalid, rsp_tdata[30] == (!rsp_tdata[13] && !rsp_tdata[0]), "tx_room inconsistent")

   // Receive start hint agrees with busy, count and failure
   `UCET_ASSERT_NOW(a_rx_want, rsp_tvalid, rsp_tdata[29] == (!rsp_tdata[13] && !rsp_tdata[1] && (rsp_tdata[12:2] == 11'd0)), "rx_start_wanted inconsistent")

endmodule

bind usb_console_event_tracker ucet_checker u_ucet_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/usb_console_event_tracker_tb.sv -----
// Self-checking testbench for usb_console_event_tracker: random stream traffic
// with idling on both sides, register settings through the APB-style port.
// Depends on ucet_pkg and the tracker RTL only.
module usb_console_event_tracker_tb;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned PHASE_ITEMS   = 200;
   localparam logic [3:0]  XFER_COMPLETE = 4'd1;
   localparam logic [2:0]  KIND_SPARE_LO = 3'd6;
   localparam logic [2:0]  KIND_SPARE_HI = 3'd7;

   // How the final phase drives the link into its sticky failure
   typedef enum int {
      FAIL_DISCONNECT, FAIL_BUS_RESET, FAIL_BUS_ERROR, FAIL_UNKNOWN_EP, FAIL_BAD_COUNT,
      FAIL_OVERSIZE, FAIL_TX_CMD, FAIL_RX_CMD, FAIL_TIMEOUT
   } fail_cause_type;

   // Tracked link state, plus the acknowledge of the latest item
   typedef struct packed {
      logic [13:0] cursor;
      logic        tx_busy;
      logic        rx_busy;
      logic [10:0] rx_left;
      logic        failed;
      logic [17:0] tx_wait;
      logic        acked;
   } link_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ucet_pkg::cfg_type cfg = '{ucet_pkg::TX_EP_RESET, ucet_pkg::RX_EP_RESET,
                              ucet_pkg::PACKET_LIMIT_RESET, ucet_pkg::RING_BYTES_RESET,
                              ucet_pkg::START_CURSOR_RESET, ucet_pkg::TX_TIMEOUT_RESET};
   link_state_type         tracked = '0;      // state after the last accepted item
   link_state_type         plan_state = '0;   // state after the last queued item
   ucet_pkg::item_type     item_fifo[$];
   ucet_pkg::result_type   expected_results[$];
   bit          steady_flow = 1'b0;
   int unsigned send_gap = 0;
   int unsigned ready_hold = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_taken = 0;
   int unsigned results_checked = 0;
   int unsigned events_acked = 0;
   int unsigned settings_used = 1;

   usb_console_event_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Next link state for one item under the current settings
   function automatic link_state_type track_item(link_state_type s, ucet_pkg::item_type it);
      logic [4:0]  ep;
      logic [23:0] remaining;
      int unsigned words;
      int unsigned nxt;
      s.acked = 1'b0;
      if (s.failed) return s;
      ep = it.ev_word[5:1];
      case (it.kind)
         ucet_pkg::KIND_EVENT: begin
            if (!it.ev_word[0] && ep != cfg.tx_endpoint_num && ep != cfg.rx_endpoint_num) begin
               s.failed = 1'b1;
            end else begin
               // acknowledge and advance the ring cursor, wrapping at the ring size
               words = cfg.ring_bytes >> 2;
               if (words > ucet_pkg::RING_WORDS_MAX) words = ucet_pkg::RING_WORDS_MAX;
               nxt = s.cursor + 1;
               if (nxt >= words) nxt = 0;
               s.cursor = 14'(nxt);
               s.acked = 1'b1;
               if (it.ev_word[0]) begin
                  // device event: disconnect or bus reset
                  if (it.ev_word[7:1] == 7'd0 && it.ev_word[11:8] <= 4'd1) s.failed = 1'b1;
               end else if (it.ev_word[9:6] == XFER_COMPLETE) begin
                  if (it.ev_word[12]) begin
                     s.failed = 1'b1;
                  end else if (ep == cfg.tx_endpoint_num) begin
                     s.tx_busy = 1'b0;
                  end else begin
                     remaining = it.trb_remaining & ucet_pkg::SIZE_MASK;
                     if (remaining > cfg.packet_limit) begin
                        s.failed = 1'b1;
                     end else begin
                        s.rx_busy = 1'b0;
                        s.rx_left = 11'(cfg.packet_limit - remaining);
                     end
                  end
               end
            end
         end
         ucet_pkg::KIND_COUNT: begin
            if ({it.pending_bytes[15:2], 2'b00} > cfg.ring_bytes) s.failed = 1'b1;
         end
         ucet_pkg::KIND_TX_START: begin
            if (!s.tx_busy) begin
               if (it.cmd_error) begin
                  s.failed = 1'b1;
               end else begin
                  s.tx_busy = 1'b1;
                  s.tx_wait = '0;
               end
            end
         end
         ucet_pkg::KIND_RX_USED: begin
            s.rx_left = (it.consumed_bytes >= s.rx_left) ? 11'd0 : s.rx_left - it.consumed_bytes;
         end
         ucet_pkg::KIND_RX_START: begin
            if (!s.rx_busy && s.rx_left == 11'd0) begin
               if (it.cmd_error) s.failed = 1'b1;
               else s.rx_busy = 1'b1;
            end
         end
         ucet_pkg::KIND_TICK: begin
            if (s.tx_busy) begin
               s.tx_wait = s.tx_wait + 18'd1;
               if (s.tx_wait >= cfg.tx_timeout_ticks) s.failed = 1'b1;
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic ucet_pkg::result_type link_report(link_state_type s);
      ucet_pkg::result_type r;
      r.tx_busy_flag    = s.tx_busy;
      r.rx_busy_flag    = s.rx_busy;
      r.rx_bytes_left   = s.rx_left;
      r.link_failed     = s.failed;
      r.ring_cursor     = s.cursor;
      r.event_acked     = s.acked;
      r.rx_start_wanted = !s.failed && !s.rx_busy && s.rx_left == 11'd0;
      r.tx_room         = !s.failed && !s.tx_busy;
      return r;
   endfunction

   function automatic logic [31:0] ep_event(logic [4:0] ep, logic [3:0] ev_type, logic err);
      return {19'd0, err, 2'b00, ev_type, ep, 1'b0};
   endfunction

   function automatic ucet_pkg::item_type make_item(logic [2:0] kind, logic [31:0] ev,
                                                    logic [23:0] trb, logic [15:0] pend,
                                                    logic err, logic [10:0] used);
      ucet_pkg::item_type it;
      it.kind           = kind;
      it.ev_word        = ev;
      it.trb_remaining  = trb;
      it.pending_bytes  = pend;
      it.cmd_error      = err;
      it.consumed_bytes = used;
      return it;
   endfunction

   // Mostly well-formed items with random content in the fields that do not matter
   function automatic ucet_pkg::item_type random_item();
      ucet_pkg::item_type it;
      int unsigned        pick;
      logic [4:0]         ep;
      it = make_item(ucet_pkg::KIND_EVENT, $urandom, 24'($urandom),
                     16'($urandom_range(65532)), $urandom_range(7) == 0,
                     11'($urandom_range(1) ? $urandom_range(64) : $urandom_range(1024)));
      ep = $urandom_range(1) ? cfg.tx_endpoint_num : cfg.rx_endpoint_num;
      pick = $urandom_range(99);
      if (pick < 28) begin
         it.ev_word = ep_event(ep, XFER_COMPLETE, 1'b0) | ($urandom & 32'hFFFF_EC00);
         it.trb_remaining = 24'($urandom_range(cfg.packet_limit));
      end else if (pick < 36) begin
         it.ev_word[0] = 1'b0;
         it.ev_word[5:1] = ep;
      end else if (pick < 44) begin
         it.ev_word[0] = 1'b1;
      end else if (pick < 54) begin
         it.kind = ucet_pkg::KIND_COUNT;
         if ($urandom_range(1)) it.pending_bytes = 16'($urandom_range(int'(cfg.ring_bytes) + 3));
      end else if (pick < 64) begin
         it.kind = ucet_pkg::KIND_TX_START;
      end else if (pick < 74) begin
         it.kind = ucet_pkg::KIND_RX_START;
      end else if (pick < 84) begin
         it.kind = ucet_pkg::KIND_RX_USED;
      end else if (pick < 97) begin
         it.kind = ucet_pkg::KIND_TICK;
      end else begin
         it.kind = $urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end
      return it;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_flow) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic queue_item(ucet_pkg::item_type it);
      item_fifo.push_back(it);
      plan_state = track_item(plan_state, it);
   endtask

   // Random items that keep the link alive; failing candidates are redrawn
   task automatic queue_live_traffic(int unsigned count);
      ucet_pkg::item_type cand;
      link_state_type     trial;
      for (int unsigned n = 0; n < count; n++) begin
         for (int tries = 0; tries < 20; tries++) begin
            cand = random_item();
            trial = track_item(plan_state, cand);
            if (!trial.failed) break;
         end
         if (!trial.failed) begin
            item_fifo.push_back(cand);
            plan_state = trial;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (item_fifo.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup then access cycle; the register takes the value at the access edge
   task automatic csr_write(ucet_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         ucet_pkg::CSR_TX_EP:        cfg.tx_endpoint_num  = value[4:0];
         ucet_pkg::CSR_RX_EP:        cfg.rx_endpoint_num  = value[4:0];
         ucet_pkg::CSR_PACKET_LIMIT: cfg.packet_limit     = value[10:0];
         ucet_pkg::CSR_RING_BYTES:   cfg.ring_bytes       = value[15:0];
         ucet_pkg::CSR_START_CURSOR: begin
            cfg.start_cursor = value[13:0];
            tracked.cursor   = value[13:0];
         end
         ucet_pkg::CSR_TX_TIMEOUT:   cfg.tx_timeout_ticks = value[17:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(int unsigned tx_ep, int unsigned rx_ep, int unsigned pkt,
                                int unsigned ring, int unsigned cursor, int unsigned timeout);
      csr_write(ucet_pkg::CSR_TX_EP, tx_ep);
      csr_write(ucet_pkg::CSR_RX_EP, rx_ep);
      csr_write(ucet_pkg::CSR_PACKET_LIMIT, pkt);
      csr_write(ucet_pkg::CSR_RING_BYTES, ring);
      csr_write(ucet_pkg::CSR_START_CURSOR, cursor);
      csr_write(ucet_pkg::CSR_TX_TIMEOUT, timeout);
      settings_used++;
   endtask

   // Item driver: holds each transaction until taken, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (item_fifo.size() > 0) begin
            ucet_pkg::item_type nxt;
            nxt = item_fifo.pop_front();
            req_tdata  <= {4'd0, nxt.consumed_bytes, nxt.cmd_error, nxt.pending_bytes,
                           nxt.trb_remaining, nxt.ev_word};
            req_tuser  <= nxt.kind;
            req_tvalid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result-side backpressure: runs of ready broken by stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         int unsigned gap;
         gap = pick_gap();
         if (rsp_tready && gap > 0) begin
            rsp_tready <= 1'b0;
            ready_hold = gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(12);
         end
      end
   end

   // Monitor: check each result transaction, then predict for each accepted item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result %08h arrived with none expected", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               ucet_pkg::result_type want;
               want = expected_results.pop_front();
               check_field("tx_busy_flag", want.tx_busy_flag, rsp_tdata[0]);
               check_field("rx_busy_flag", want.rx_busy_flag, rsp_tdata[1]);
               check_field("rx_bytes_left", want.rx_bytes_left, rsp_tdata[12:2]);
               check_field("link_failed", want.link_failed, rsp_tdata[13]);
               check_field("ring_cursor", want.ring_cursor, rsp_tdata[27:14]);
               check_field("event_acked", want.event_acked, rsp_tdata[28]);
               check_field("rx_start_wanted", want.rx_start_wanted, rsp_tdata[29]);
               check_field("tx_room", want.tx_room, rsp_tdata[30]);
               check_field("padding", 0, rsp_tdata[31]);
            end
            results_checked++;
         end
         if (req_tvalid && req_tready) begin
            tracked = track_item(tracked, make_item(req_tuser, req_tdata[31:0], req_tdata[55:32],
                                                    req_tdata[71:56], req_tdata[72],
                                                    req_tdata[83:73]));
            expected_results.push_back(link_report(tracked));
            items_taken++;
            if (tracked.acked) events_acked++;
         end
      end
   end

   // Watchdog
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: no completion within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      fail_cause_type cause;
      int unsigned    tx_ep;
      int unsigned    rx_ep;
      int unsigned    pkt;
      int unsigned    ring;
      logic [4:0]     ep;
      logic [31:0]    ev;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under reset settings: endpoint 1 transmit, 2 receive, 512-byte buffer
      plan_state = tracked;
      queue_item(make_item(ucet_pkg::KIND_COUNT, 0, 0, 16'd0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_COUNT, 0, 0, 16'd4099, 0, 0)); // masks to ring size
      queue_item(make_item(ucet_pkg::KIND_TX_START, 0, 0, 0, 1'b0, 0));
      queue_item(make_item(ucet_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_TX_START, 0, 0, 0, 1'b1, 0));  // busy: error ignored
      queue_item(make_item(ucet_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(5'd1, XFER_COMPLETE, 1'b0),
                           0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b0, 0));
      queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b1, 0));  // busy: ignored
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(5'd2, XFER_COMPLETE, 1'b0),
                           24'd0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b1, 0));  // holding bytes: ignored
      queue_item(make_item(ucet_pkg::KIND_RX_USED, 0, 0, 0, 0, 11'd100));
      queue_item(make_item(ucet_pkg::KIND_RX_USED, 0, 0, 0, 0, 11'd1024)); // saturates at zero
      queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(5'd2, XFER_COMPLETE, 1'b0),
                           24'd512, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, 32'hFFFF_FFFF, 24'hFF_FFFF, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(5'd2, 4'hF, 1'b1) | 32'hFFFF_EC00,
                           0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT,
                           ep_event(5'd1, XFER_COMPLETE, 1'b0) | 32'hFFFF_EC00, 0, 0, 0, 0));
      queue_item(make_item(KIND_SPARE_LO, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFC, 1'b1, 11'd1024));
      queue_item(make_item(KIND_SPARE_HI, 0, 0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_TICK, 0, 0, 0, 0, 0));      // transmit idle: no count
      queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(5'd2, XFER_COMPLETE, 1'b0),
                           24'd511, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_RX_USED, 0, 0, 0, 0, 11'd0));
      wait_drained();

      // Random traffic under extreme, shared-endpoint and random settings
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: apply_setting(0, 31, 1024, 4, 0, 262143);
            1: apply_setting(31, 0, 1, 65532, 16382, 1);
            2: apply_setting(5, 5, 64, 16, 9, 7);           // cursor starts past the ring end
            default: begin
               tx_ep = $urandom_range(31);
               rx_ep = ($urandom_range(3) == 0) ? tx_ep : $urandom_range(31);
               ring = $urandom_range(1) ? 4 * $urandom_range(1, 64) : 4 * $urandom_range(1, 16383);
               apply_setting(tx_ep, rx_ep, $urandom_range(1, 1024), ring,
                             $urandom_range(1) ? $urandom_range(16382) : $urandom_range(ring / 4 + 4),
                             $urandom_range(2, 60));
            end
         endcase
         steady_flow = (phase == 0) || ($urandom_range(3) == 0);
         plan_state = tracked;
         queue_live_traffic(PHASE_ITEMS);
         wait_drained();
      end

      // Final phase: distinct endpoints, then one failure and items that must be ignored
      steady_flow = 1'b0;
      tx_ep = $urandom_range(31);
      rx_ep = (tx_ep + $urandom_range(1, 31)) % 32;
      pkt = $urandom_range(1, 1023);
      ring = 4 * $urandom_range(1, 16382);
      apply_setting(tx_ep, rx_ep, pkt, ring, $urandom_range(16382), $urandom_range(1, 12));
      plan_state = tracked;
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(tx_ep, XFER_COMPLETE, 1'b0),
                           0, 0, 0, 0));
      queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(rx_ep, XFER_COMPLETE, 1'b0),
                           pkt, 0, 0, 0));
      cause = fail_cause_type'($urandom_range(8));
      ev = $urandom;
      case (cause)
         FAIL_DISCONNECT, FAIL_BUS_RESET: begin
            ev[0] = 1'b1;
            ev[7:1] = 7'd0;
            ev[11:8] = (cause == FAIL_BUS_RESET) ? 4'd1 : 4'd0;
            queue_item(make_item(ucet_pkg::KIND_EVENT, ev, 0, 0, 0, 0));
         end
         FAIL_BUS_ERROR: begin
            queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(tx_ep, XFER_COMPLETE, 1'b1) |
                                 (ev & 32'hFFFF_E000), 0, 0, 0, 0));
         end
         FAIL_UNKNOWN_EP: begin
            ep = tx_ep;
            while (ep == tx_ep || ep == rx_ep) ep = ep + 5'd1;
            ev[0] = 1'b0;
            ev[5:1] = ep;
            queue_item(make_item(ucet_pkg::KIND_EVENT, ev, 0, 0, 0, 0));
         end
         FAIL_BAD_COUNT: begin
            queue_item(make_item(ucet_pkg::KIND_COUNT, 0, 0,
                                 16'($urandom_range(ring + 4, 65532)), 0, 0));
         end
         FAIL_OVERSIZE: begin
            queue_item(make_item(ucet_pkg::KIND_EVENT, ep_event(rx_ep, XFER_COMPLETE, 1'b0),
                                 24'($urandom_range(pkt + 1, 24'hFF_FFFF)), 0, 0, 0));
         end
         FAIL_TX_CMD: queue_item(make_item(ucet_pkg::KIND_TX_START, 0, 0, 0, 1'b1, 0));
         FAIL_RX_CMD: queue_item(make_item(ucet_pkg::KIND_RX_START, 0, 0, 0, 1'b1, 0));
         default: begin
            queue_item(make_item(ucet_pkg::KIND_TX_START, 0, 0, 0, 1'b0, 0));
            while (!plan_state.failed) queue_item(make_item(ucet_pkg::KIND_TICK, 0, 0, 0, 0, 0));
         end
      endcase
      for (int n = 0; n < 24; n++) begin
         queue_item(make_item($urandom_range(7), $urandom, 24'($urandom),
                              16'($urandom_range(65532)), $urandom_range(1),
                              11'($urandom_range(1024))));
      end
      wait_drained();

      $display("Covered %0d items over %0d register settings, %0d results checked, %0d events acked",
               items_taken, settings_used, results_checked, events_acked);
      $display("Sticky failure exercised through %s, followed by ignored traffic", cause.name());
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ucet_pkg.sv
hdl/ucet_csr.sv
hdl/ucet_core.sv
hdl/usb_console_event_tracker.sv
hdl/ucet_checker.sv
test/usb_console_event_tracker_tb.sv
